>>> hdl/lfbpe_pkg.sv
// Shared types, constants and helper functions for the LCD frame store pixel expander.
// Used by every module under hdl/; depends on nothing else.
package lfbpe_pkg;

  // Default size of the frame store in bytes.
  localparam int unsigned FrameBytesDef = 262144;

  // Byte addresses reach 2 * (1023 * 2047 + 1023) + 1, so 22 bits cover every case.
  localparam int unsigned AddrW = 22;

  typedef logic [AddrW-1:0] addr_t;

  // Pixel formats of the frame store.
  typedef enum logic [1:0] {
    ModePage1  = 2'd0,
    ModeGray4  = 2'd1,
    ModeRgb444 = 2'd2,
    ModeRgb565 = 2'd3
  } pixel_mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgFrameWidth  = 3'd0,
    CfgFrameHeight = 3'd1,
    CfgPixelMode   = 3'd2,
    CfgBacklightOn = 3'd3,
    CfgBgLitRgb    = 3'd4,
    CfgBgDefRgb    = 3'd5,
    CfgFgRgb       = 3'd6
  } cfg_reg_e;

  // Live configuration, held in the top level.
  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    pixel_mode_e pixel_mode;
    logic        backlight_on;
    logic [23:0] bg_lit_rgb;
    logic [23:0] bg_default_rgb;
    logic [23:0] fg_rgb;
  } cfg_t;

  // Request leaving the address stages for the frame store.
  typedef struct packed {
    logic       fetch;
    logic       in_range;
    logic [2:0] y_lo;
    addr_t      addr;
    logic [7:0] data;
  } store_req_t;

  // Read result handed from the frame store to the color expander.
  typedef struct packed {
    logic       in_range;
    logic [2:0] y_lo;
    logic       a0;
    logic       addr_ok;
    logic       next_ok;
    logic [7:0] even_byte;
    logic [7:0] odd_byte;
  } store_rd_t;

  // z * ceil(2^15 / 15), so that (bg * GrayRecip[z]) >> 15 equals (z * bg) / 15.
  localparam logic [15:0] GrayRecip [16] = '{
    16'd0,     16'd2185,  16'd4370,  16'd6555,
    16'd8740,  16'd10925, 16'd13110, 16'd15295,
    16'd17480, 16'd19665, 16'd21850, 16'd24035,
    16'd26220, 16'd28405, 16'd30590, 16'd32775
  };

  // One channel of a four-bit gray pixel: bg - (z * bg) / 15.
  function automatic logic [7:0] gray_level(input logic [7:0] bg, input logic [3:0] z);
    logic [23:0] prod;
    prod = 24'(bg) * 24'(GrayRecip[z]);
    return bg - prod[22:15];
  endfunction

endpackage

>>> hdl/lcd_framebuffer_pixel_expander_unit.sv
// Top level of the LCD frame store pixel expander: configuration registers and pipeline.
// Depends on lfbpe_pkg, lfbpe_front, lfbpe_store and lfbpe_expand.
//
// Usage: each request on the slave stream either writes one byte into the frame store
// (tuser low) or fetches one pixel (tuser high). A write gives no response; a fetch
// gives one response on the master stream with the pixel as 8-bit R, G, B in tdata and
// the in-panel flag in tuser. Responses leave in request order.
// Throughput: one request per cycle while nothing stalls; the pipeline is range check,
// row multiply, memory read and color expansion, with one memory access per request.
// Configuration registers are written on the plain port; the user writes them only
// while no request is in flight, and the block itself does not enforce this.
// Reset: the configuration returns to its defaults and a clearing pass zeroes the
// frame store, one even/odd byte pair per cycle; s_axis_tready stays low until it ends.
// Stall: when m_axis_tready is low the response holds, the stages behind it fill up,
// and s_axis_tready drops once no stage is free; nothing is lost or repeated.
module lcd_framebuffer_pixel_expander_unit #(
  parameter int unsigned FRAME_BYTES = lfbpe_pkg::FrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_address[17:0], byte_data[25:18], pixel_x[35:26], pixel_y[45:36], zero[47:46]
  input  logic [47:0] s_axis_tdata,
  // action[0]
  input  logic        s_axis_tuser,
  // Response stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [23:0] m_axis_tdata,
  // in_range[0]
  output logic        m_axis_tuser
);

  lfbpe_pkg::cfg_t       cfg_q;
  logic                  busy;
  logic                  front_ready;
  logic                  req_valid, req_ready;
  lfbpe_pkg::store_req_t req;
  logic                  rd_valid, rd_ready;
  lfbpe_pkg::store_rd_t  rd;
  logic [23:0]           rgb;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= 11'd128;
      cfg_q.frame_height   <= 11'd64;
      cfg_q.pixel_mode     <= lfbpe_pkg::ModePage1;
      cfg_q.backlight_on   <= 1'b0;
      cfg_q.bg_lit_rgb     <= 24'h000000;
      cfg_q.bg_default_rgb <= 24'h000000;
      cfg_q.fg_rgb         <= 24'h000000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lfbpe_pkg::CfgFrameWidth:  cfg_q.frame_width    <= cfg_data_i[10:0];
        lfbpe_pkg::CfgFrameHeight: cfg_q.frame_height   <= cfg_data_i[10:0];
        lfbpe_pkg::CfgPixelMode:
          cfg_q.pixel_mode <= lfbpe_pkg::pixel_mode_e'(cfg_data_i[1:0]);
        lfbpe_pkg::CfgBacklightOn: cfg_q.backlight_on   <= cfg_data_i[0];
        lfbpe_pkg::CfgBgLitRgb:    cfg_q.bg_lit_rgb     <= cfg_data_i;
        lfbpe_pkg::CfgBgDefRgb:    cfg_q.bg_default_rgb <= cfg_data_i;
        lfbpe_pkg::CfgFgRgb:       cfg_q.fg_rgb         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // No requests enter while the frame store is being cleared.
  assign s_axis_tready = front_ready && !busy;

  lfbpe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (s_axis_tvalid && !busy),
    .in_ready_o     (front_ready),
    .action_i       (s_axis_tuser),
    .byte_address_i (s_axis_tdata[17:0]),
    .byte_data_i    (s_axis_tdata[25:18]),
    .pixel_x_i      (s_axis_tdata[35:26]),
    .pixel_y_i      (s_axis_tdata[45:36]),
    .req_valid_o    (req_valid),
    .req_ready_i    (req_ready),
    .req_o          (req)
  );

  lfbpe_store #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .busy_o      (busy),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rd_valid_o  (rd_valid),
    .rd_ready_i  (rd_ready),
    .rd_o        (rd)
  );

  lfbpe_expand u_expand (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .rd_valid_i     (rd_valid),
    .rd_ready_o     (rd_ready),
    .rd_i           (rd),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_rgb_o      (rgb),
    .out_in_range_o (m_axis_tuser)
  );

  // Internal color is R in the high byte; the stream carries red in the low byte.
  assign m_axis_tdata = {rgb[7:0], rgb[15:8], rgb[23:16]};

endmodule

>>> hdl/lfbpe_front.sv
// Two address stages: range check and row selection, then the row multiply.
// Depends on lfbpe_pkg.
module lfbpe_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lfbpe_pkg::cfg_t        cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   action_i,
  input  logic [17:0]            byte_address_i,
  input  logic [7:0]             byte_data_i,
  input  logic [9:0]             pixel_x_i,
  input  logic [9:0]             pixel_y_i,
  output logic                   req_valid_o,
  input  logic                   req_ready_i,
  output lfbpe_pkg::store_req_t  req_o
);

  typedef struct packed {
    logic        fetch;
    logic        in_range;
    logic [9:0]  x;
    logic [9:0]  row;
    logic [2:0]  y_lo;
    logic [17:0] wr_addr;
    logic [7:0]  wr_data;
  } s1_t;

  s1_t                   s1_d, s1_q;
  logic                  s1_valid_q;
  lfbpe_pkg::store_req_t s2_d, s2_q;
  logic                  s2_valid_q;
  logic                  s1_ready, s2_ready;
  logic                  s1_en, s2_en;
  logic [20:0]           pix_idx;

  // Stage handshakes: a stage takes a request when it is empty or draining.
  assign s2_ready   = !s2_valid_q || req_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s1_en      = in_valid_i && s1_ready;
  assign s2_en      = s1_valid_q && s2_ready;
  assign in_ready_o = s1_ready;

  // Stage one: panel bounds and the page row for the current pixel format.
  always_comb begin
    s1_d.fetch    = action_i;
    s1_d.in_range = ({1'b0, pixel_x_i} < cfg_i.frame_width) &&
                    ({1'b0, pixel_y_i} < cfg_i.frame_height);
    s1_d.x        = pixel_x_i;
    s1_d.y_lo     = pixel_y_i[2:0];
    s1_d.wr_addr  = byte_address_i;
    s1_d.wr_data  = byte_data_i;
    case (cfg_i.pixel_mode)
      lfbpe_pkg::ModePage1: s1_d.row = {3'b000, pixel_y_i[9:3]};
      lfbpe_pkg::ModeGray4: s1_d.row = {1'b0, pixel_y_i[9:1]};
      default:              s1_d.row = pixel_y_i;
    endcase
  end

  // Stage two: row times width plus column, doubled for two-byte pixels.
  assign pix_idx = 21'(s1_q.row) * 21'(cfg_i.frame_width) + 21'(s1_q.x);

  always_comb begin
    s2_d.fetch    = s1_q.fetch;
    s2_d.in_range = s1_q.in_range;
    s2_d.y_lo     = s1_q.y_lo;
    s2_d.data     = s1_q.wr_data;
    if (!s1_q.fetch) begin
      s2_d.addr = lfbpe_pkg::addr_t'(s1_q.wr_addr);
    end else if (cfg_i.pixel_mode == lfbpe_pkg::ModeRgb444 ||
                 cfg_i.pixel_mode == lfbpe_pkg::ModeRgb565) begin
      s2_d.addr = {pix_idx, 1'b0};
    end else begin
      s2_d.addr = {1'b0, pix_idx};
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_q <= s1_d;
    end
    if (s2_en) begin
      s2_q <= s2_d;
    end
  end

  assign req_valid_o = s2_valid_q;
  assign req_o       = s2_q;

endmodule

>>> hdl/lfbpe_store.sv
// Frame store split into even and odd byte banks, with its clearing pass after reset.
// Depends on lfbpe_pkg.
module lfbpe_store #(
  parameter int unsigned FRAME_BYTES = lfbpe_pkg::FrameBytesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  output logic                  busy_o,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  lfbpe_pkg::store_req_t req_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output lfbpe_pkg::store_rd_t  rd_o
);

  localparam int unsigned EvenDepth = (FRAME_BYTES + 1) / 2;
  localparam int unsigned OddDepth  = FRAME_BYTES / 2;
  localparam int unsigned IdxW      = $clog2(EvenDepth);
  localparam logic [lfbpe_pkg::AddrW:0] FbLimit = (lfbpe_pkg::AddrW + 1)'(FRAME_BYTES);

  logic [7:0] mem_even [EvenDepth];
  logic [7:0] mem_odd  [OddDepth];

  logic                 clearing_q;
  logic [IdxW-1:0]      clr_idx_q;
  logic                 en;
  logic [IdxW-1:0]      idx;
  logic                 addr_ok, next_ok;
  logic                 we_even, we_odd;
  logic [IdxW-1:0]      widx;
  logic [7:0]           wdata;
  logic                 valid_q;
  lfbpe_pkg::store_rd_t rd_q;

  assign req_ready_o = !valid_q || rd_ready_i;
  assign en          = req_valid_i && req_ready_o;
  assign busy_o      = clearing_q;

  // Bank index and bounds of the addressed byte and the one after it.
  assign idx     = req_i.addr[IdxW:1];
  assign addr_ok = {1'b0, req_i.addr} < FbLimit;
  assign next_ok = ({1'b0, req_i.addr} + 1'b1) < FbLimit;

  // Write port: clearing pass first, then byte writes from the pipeline.
  always_comb begin
    if (clearing_q) begin
      we_even = 1'b1;
      we_odd  = {1'b0, clr_idx_q} < (IdxW + 1)'(OddDepth);
      widx    = clr_idx_q;
      wdata   = 8'h00;
    end else begin
      we_even = en && !req_i.fetch && addr_ok && !req_i.addr[0];
      we_odd  = en && !req_i.fetch && addr_ok && req_i.addr[0];
      widx    = idx;
      wdata   = req_i.data;
    end
  end

  // Clearing pass over every row of both banks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == IdxW'(EvenDepth - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Memory banks with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_even) begin
      mem_even[widx] <= wdata;
    end
    if (we_odd) begin
      mem_odd[widx] <= wdata;
    end
    if (en) begin
      rd_q.even_byte <= mem_even[idx];
      rd_q.odd_byte  <= mem_odd[idx];
      rd_q.in_range  <= req_i.in_range;
      rd_q.y_lo      <= req_i.y_lo;
      rd_q.a0        <= req_i.addr[0];
      rd_q.addr_ok   <= addr_ok;
      rd_q.next_ok   <= next_ok;
    end
  end

  // Only fetches carry on; a write ends here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_ready_o) begin
      valid_q <= req_valid_i && req_i.fetch;
    end
  end

  assign rd_valid_o = valid_q;
  assign rd_o       = rd_q;

endmodule

>>> hdl/lfbpe_expand.sv
// Color expansion of the fetched bytes into 8-bit R, G, B, and the output register.
// Depends on lfbpe_pkg.
module lfbpe_expand (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfbpe_pkg::cfg_t      cfg_i,
  input  logic                 rd_valid_i,
  output logic                 rd_ready_o,
  input  lfbpe_pkg::store_rd_t rd_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [23:0]          out_rgb_o,
  output logic                 out_in_range_o
);

  logic        valid_q;
  logic [23:0] rgb_d, rgb_q;
  logic        in_range_q;
  logic [7:0]  byte_v, lo_byte, hi_byte;
  logic [15:0] word_v;
  logic [23:0] bg;
  logic [3:0]  z;
  logic [4:0]  r5, b5;
  logic [5:0]  g6;

  assign rd_ready_o = !valid_q || out_ready_i;

  // Byte and word views; bytes beyond the store read as zero.
  always_comb begin
    lo_byte = rd_i.addr_ok ? rd_i.even_byte : 8'h00;
    hi_byte = rd_i.next_ok ? rd_i.odd_byte : 8'h00;
    if (!rd_i.addr_ok) begin
      byte_v = 8'h00;
    end else if (rd_i.a0) begin
      byte_v = rd_i.odd_byte;
    end else begin
      byte_v = rd_i.even_byte;
    end
    word_v = {hi_byte, lo_byte};
    bg     = cfg_i.backlight_on ? cfg_i.bg_lit_rgb : cfg_i.bg_default_rgb;
    z      = rd_i.y_lo[0] ? byte_v[7:4] : byte_v[3:0];
    r5     = word_v[15:11];
    g6     = word_v[10:5];
    b5     = word_v[4:0];
  end

  // Per-format expansion; a pixel off the panel is black.
  always_comb begin
    if (!rd_i.in_range) begin
      rgb_d = 24'h000000;
    end else begin
      case (cfg_i.pixel_mode)
        lfbpe_pkg::ModePage1: begin
          rgb_d = byte_v[rd_i.y_lo] ? cfg_i.fg_rgb : bg;
        end
        lfbpe_pkg::ModeGray4: begin
          rgb_d = {lfbpe_pkg::gray_level(bg[23:16], z),
                   lfbpe_pkg::gray_level(bg[15:8], z),
                   lfbpe_pkg::gray_level(bg[7:0], z)};
        end
        lfbpe_pkg::ModeRgb444: begin
          rgb_d = {word_v[11:8], word_v[11:8], word_v[7:4], word_v[7:4],
                   word_v[3:0], word_v[3:0]};
        end
        default: begin
          rgb_d = {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
        end
      endcase
    end
  end

  // Output valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rd_ready_o) begin
      valid_q <= rd_valid_i;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (rd_valid_i && rd_ready_o) begin
      rgb_q      <= rgb_d;
      in_range_q <= rd_i.in_range;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_rgb_o      = rgb_q;
  assign out_in_range_o = in_range_q;

endmodule

>>> test/lcd_framebuffer_pixel_expander_unit_tb.sv
// Self-checking testbench for the LCD frame store pixel expander: byte writes and pixel
// fetches go on the request stream; each fetch is checked against a model or a known color.
// Depends on lfbpe_pkg and lcd_framebuffer_pixel_expander_unit.
module lcd_framebuffer_pixel_expander_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FrameBytes = lfbpe_pkg::FrameBytesDef;
  // Cycles a request may still spend in the pipeline after the last response.
  localparam int PipeDepth = 8;
  // Cycles without any handshake before the run is declared hung; covers the clearing pass.
  localparam int QuietLimit = 600000;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 150;
  localparam int LongHold = 400;

  typedef enum bit {
    ActWrite = 1'b0,
    ActFetch = 1'b1
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [17:0] addr;
    logic [7:0]  data;
    logic [9:0]  x;
    logic [9:0]  y;
  } request_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       in_range;
  } pixel_t;

  // One line of the directed plan: a register write or a request, optionally with a
  // result that is known in advance.
  typedef struct packed {
    logic                 is_cfg;
    lfbpe_pkg::cfg_reg_e  reg_idx;
    logic [23:0]          value;
    request_t             rq;
    logic                 known;
    pixel_t               want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Shadow of the frame store and the configuration.
  bit [7:0]               store_shadow [FrameBytes];
  bit [10:0]              panel_width = 11'd128;
  bit [10:0]              panel_height = 11'd64;
  lfbpe_pkg::pixel_mode_e panel_mode = lfbpe_pkg::ModePage1;
  bit                     backlight = 1'b0;
  bit [23:0]              bg_lit = '0;
  bit [23:0]              bg_default = '0;
  bit [23:0]              fg_color = '0;

  pixel_t      pending_pixels [$];
  int          mismatches = 0;
  int          requests_sent = 0;
  int          quiet_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_req = 0;

  lcd_framebuffer_pixel_expander_unit #(
    .FRAME_BYTES(FrameBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Byte of the shadow store; bytes past the end of the store read as zero.
  function automatic bit [7:0] stored_byte(input int unsigned a);
    return (a < FrameBytes) ? store_shadow[a] : 8'h00;
  endfunction

  // First store byte that holds pixel (x, y) in the current mode.
  function automatic int unsigned pixel_byte(input bit [9:0] x, input bit [9:0] y);
    int unsigned w;
    w = panel_width;
    case (panel_mode)
      lfbpe_pkg::ModePage1: return (int'(y) >> 3) * w + x;
      lfbpe_pkg::ModeGray4: return (int'(y) >> 1) * w + x;
      default:              return 2 * (int'(y) * w + x);
    endcase
  endfunction

  // Gray level z darkens the background channel in fifteen steps.
  function automatic bit [7:0] gray_shade(input bit [7:0] bg, input bit [3:0] z);
    int unsigned b;
    b = bg;
    return 8'(b - (int'(z) * b) / 15);
  endfunction

  // Color of pixel (x, y) as the block should return it.
  function automatic pixel_t predict_pixel(input bit [9:0] x, input bit [9:0] y);
    pixel_t      px;
    int unsigned base;
    bit [15:0]   word;
    bit [23:0]   bg;
    bit [3:0]    z;
    px = '0;
    if (x >= panel_width || y >= panel_height) return px;
    px.in_range = 1'b1;
    bg = backlight ? bg_lit : bg_default;
    base = pixel_byte(x, y);
    word = {stored_byte(base + 1), stored_byte(base)};
    case (panel_mode)
      lfbpe_pkg::ModePage1: begin
        {px.red, px.green, px.blue} = word[y[2:0]] ? fg_color : bg;
      end
      lfbpe_pkg::ModeGray4: begin
        z = y[0] ? word[7:4] : word[3:0];
        px.red   = gray_shade(bg[23:16], z);
        px.green = gray_shade(bg[15:8], z);
        px.blue  = gray_shade(bg[7:0], z);
      end
      lfbpe_pkg::ModeRgb444: begin
        px.red   = 8'd17 * word[11:8];
        px.green = 8'd17 * word[7:4];
        px.blue  = 8'd17 * word[3:0];
      end
      default: begin
        px.red   = {word[15:11], word[15:13]};
        px.green = {word[10:5], word[10:9]};
        px.blue  = {word[4:0], word[4:2]};
      end
    endcase
    return px;
  endfunction

  function automatic plan_row_t cfg_row(input lfbpe_pkg::cfg_reg_e idx,
                                        input logic [23:0] value);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.value = value;
    return row;
  endfunction

  function automatic plan_row_t write_row(input logic [17:0] addr, input logic [7:0] data);
    plan_row_t row;
    row = '0;
    row.rq = '{ActWrite, addr, data, 10'h3FF, 10'h3FF};
    return row;
  endfunction

  function automatic plan_row_t fetch_row(input logic [9:0] x, input logic [9:0] y);
    plan_row_t row;
    row = '0;
    row.rq = '{ActFetch, 18'h3FFFF, 8'hFF, x, y};
    return row;
  endfunction

  // Fetch whose color is plain to see; rgb holds red in bits 23:16.
  function automatic plan_row_t known_row(input logic [9:0] x, input logic [9:0] y,
                                          input logic [23:0] rgb, input logic in_panel);
    plan_row_t row;
    row = fetch_row(x, y);
    row.known = 1'b1;
    row.want = {rgb, in_panel};
    return row;
  endfunction

  // Offer one request, with random idle cycles first, and record what it should do.
  task automatic send_request(input request_t rq, input bit known, input pixel_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, rq.y, rq.x, rq.data, rq.addr};
    s_axis_tuser  <= rq.action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
    if (rq.action == ActWrite) begin
      if (rq.addr < FrameBytes) store_shadow[rq.addr] = rq.data;
    end else begin
      pending_pixels.push_back(known ? want : predict_pixel(rq.x, rq.y));
    end
  endtask

  task automatic send_plain(input request_t rq);
    send_request(rq, 1'b0, '0);
  endtask

  // Stop offering requests and wait until the pipeline has emptied.
  task automatic settle_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  // Write one configuration register and mirror it in the shadow.
  task automatic write_register(input lfbpe_pkg::cfg_reg_e idx, input logic [23:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      lfbpe_pkg::CfgFrameWidth:  panel_width = value[10:0];
      lfbpe_pkg::CfgFrameHeight: panel_height = value[10:0];
      lfbpe_pkg::CfgPixelMode:   panel_mode = lfbpe_pkg::pixel_mode_e'(value[1:0]);
      lfbpe_pkg::CfgBacklightOn: backlight = value[0];
      lfbpe_pkg::CfgBgLitRgb:    bg_lit = value;
      lfbpe_pkg::CfgBgDefRgb:    bg_default = value;
      lfbpe_pkg::CfgFgRgb:       fg_color = value;
      default: ;
    endcase
  endtask

  // Random pixel inside the current panel.
  function automatic request_t panel_fetch();
    return '{ActFetch, 18'($urandom()), 8'($urandom()),
             10'($urandom_range(int'(panel_width) - 1)),
             10'($urandom_range(int'(panel_height) - 1))};
  endfunction

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endtask

  // Each response is matched against the oldest outstanding fetch.
  always @(posedge clk_i) begin : check_responses
    pixel_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("response with no fetch outstanding: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("red", want.red, m_axis_tdata[7:0]);
        compare_field("green", want.green, m_axis_tdata[15:8]);
        compare_field("blue", want.blue, m_axis_tdata[23:16]);
        compare_field("in_range", want.in_range, m_axis_tuser);
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("lcd_framebuffer_pixel_expander_unit_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t   plan [$];
    request_t    rq;
    int unsigned base;
    int          phase_end;
    int          pick;
    bit          paused;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed plan: reset state, each mode, the extremes of the panel size, a zero width,
    // pixels past the end of the store and the last store byte.
    plan = '{
      known_row(10'd0, 10'd0, 24'h000000, 1'b1),
      known_row(10'd127, 10'd63, 24'h000000, 1'b1),
      known_row(10'd128, 10'd0, 24'h000000, 1'b0),
      known_row(10'd1023, 10'd1023, 24'h000000, 1'b0),
      cfg_row(lfbpe_pkg::CfgFgRgb, 24'hFFFFFF),
      cfg_row(lfbpe_pkg::CfgBgDefRgb, 24'h123456),
      cfg_row(lfbpe_pkg::CfgBgLitRgb, 24'hA5C3E1),
      write_row(18'd0, 8'h01),
      known_row(10'd0, 10'd0, 24'hFFFFFF, 1'b1),
      known_row(10'd0, 10'd1, 24'h123456, 1'b1),
      cfg_row(lfbpe_pkg::CfgBacklightOn, 24'd1),
      known_row(10'd0, 10'd1, 24'hA5C3E1, 1'b1),
      write_row(18'd128, 8'h80),
      fetch_row(10'd0, 10'd15),
      cfg_row(lfbpe_pkg::CfgPixelMode, 24'(lfbpe_pkg::ModeGray4)),
      write_row(18'd3, 8'hF0),
      known_row(10'd3, 10'd0, 24'hA5C3E1, 1'b1),
      known_row(10'd3, 10'd1, 24'h000000, 1'b1),
      write_row(18'd5, 8'h07),
      fetch_row(10'd5, 10'd0),
      cfg_row(lfbpe_pkg::CfgPixelMode, 24'(lfbpe_pkg::ModeRgb444)),
      write_row(18'd2, 8'hAB),
      write_row(18'd3, 8'h0F),
      known_row(10'd1, 10'd0, 24'hFFAABB, 1'b1),
      cfg_row(lfbpe_pkg::CfgPixelMode, 24'(lfbpe_pkg::ModeRgb565)),
      write_row(18'd4, 8'hFF),
      write_row(18'd5, 8'hFF),
      known_row(10'd2, 10'd0, 24'hFFFFFF, 1'b1),
      fetch_row(10'd1, 10'd0),
      cfg_row(lfbpe_pkg::CfgFrameWidth, 24'd1024),
      cfg_row(lfbpe_pkg::CfgFrameHeight, 24'd1024),
      known_row(10'd1023, 10'd1023, 24'h000000, 1'b1),
      write_row(18'h3FFFF, 8'h5A),
      fetch_row(10'd1023, 10'd127),
      cfg_row(lfbpe_pkg::CfgFrameWidth, 24'd0),
      known_row(10'd0, 10'd0, 24'h000000, 1'b0),
      cfg_row(lfbpe_pkg::CfgFrameWidth, 24'd1),
      cfg_row(lfbpe_pkg::CfgFrameHeight, 24'd1),
      fetch_row(10'd0, 10'd0),
      known_row(10'd1, 10'd0, 24'h000000, 1'b0),
      known_row(10'd0, 10'd1, 24'h000000, 1'b0)
    };
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle_idle();
        write_register(plan[i].reg_idx, plan[i].value);
      end else begin
        send_request(plan[i].rq, plan[i].known, plan[i].want);
      end
    end

    // Random phases: every mode under several idling patterns and panel sizes.
    for (int p = 0; p < PhaseCount; p++) begin
      settle_idle();
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      if (p == 7 || p == 10) begin
        write_register(lfbpe_pkg::CfgFrameWidth, 24'd1024);
        write_register(lfbpe_pkg::CfgFrameHeight, 24'd1024);
      end else if (p == 5) begin
        write_register(lfbpe_pkg::CfgFrameWidth, 24'($urandom_range(1, 1024)));
        write_register(lfbpe_pkg::CfgFrameHeight, 24'($urandom_range(1, 16)));
      end else begin
        write_register(lfbpe_pkg::CfgFrameWidth, 24'($urandom_range(1, 48)));
        write_register(lfbpe_pkg::CfgFrameHeight, 24'($urandom_range(1, 48)));
      end
      write_register(lfbpe_pkg::CfgPixelMode, 24'(p % 4));
      write_register(lfbpe_pkg::CfgBacklightOn, 24'(p % 2));
      write_register(lfbpe_pkg::CfgBgLitRgb, 24'($urandom()));
      write_register(lfbpe_pkg::CfgBgDefRgb, 24'($urandom()));
      write_register(lfbpe_pkg::CfgFgRgb, 24'($urandom()));

      case ((p + p / 4) % 4)
        1: tx_idle_pct = 81;
        2: rx_stall_pct = 81;
        3: begin
          tx_idle_pct = 12;
          rx_stall_pct = 12;
        end
        default: ;
      endcase

      // Hold the response side off while fetches keep coming, so the pipeline backs up.
      if (p == 0) begin
        rx_hold_req = LongHold;
        repeat (40) send_plain(panel_fetch());
      end

      phase_end = requests_sent + PhaseItems;
      paused = 1'b0;
      while (requests_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // Paint a pixel, then read it back and maybe another one.
          rq = panel_fetch();
          base = pixel_byte(rq.x, rq.y);
          for (int k = 0; k < ((panel_mode >= lfbpe_pkg::ModeRgb444) ? 2 : 1); k++) begin
            if (base + k < FrameBytes) begin
              send_plain('{ActWrite, 18'(base + k), 8'($urandom()),
                           10'($urandom()), 10'($urandom())});
            end
          end
          send_plain(rq);
          if ($urandom_range(1)) send_plain(panel_fetch());
        end else if (pick < 85) begin
          send_plain('{ActWrite, 18'($urandom()), 8'($urandom()),
                       10'($urandom()), 10'($urandom())});
        end else begin
          send_plain('{ActFetch, 18'($urandom()), 8'($urandom()),
                       10'($urandom()), 10'($urandom())});
        end
        // Halfway through, let every outstanding fetch come back before going on.
        if (!paused && requests_sent >= phase_end - PhaseItems / 2) begin
          paused = 1'b1;
          settle_idle();
        end
      end
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("lcd_framebuffer_pixel_expander_unit_tb: done, clean");
    end else begin
      $display("lcd_framebuffer_pixel_expander_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/lfbpe_pkg.sv
hdl/lfbpe_front.sv
hdl/lfbpe_store.sv
hdl/lfbpe_expand.sv
hdl/lcd_framebuffer_pixel_expander_unit.sv
test/lcd_framebuffer_pixel_expander_unit_tb.sv
